// ----- hdl/pcps_pkg.sv -----
package pcps_pkg;

  // Field widths fixed at the ports
  localparam int COORD_IN_W = 16;
  localparam int BOX_W      = 16;
  localparam int CUTOFF_W   = 32;
  localparam int ROW_W      = 6;
  localparam int IDX_OUT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X  = 2'd0,
    REG_BOX_Y  = 2'd1,
    REG_BOX_Z  = 2'd2,
    REG_CUTOFF = 2'd3
  } cfg_reg_t;

endpackage

// ----- hdl/pcps_axis_unit.sv -----
module pcps_axis_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic [COORD_BITS-1:0]                  coord_a,
  input  logic [COORD_BITS-1:0]                  coord_b,
  input  logic [pcps_pkg::BOX_W-1:0]             box,
  output logic [2*((COORD_BITS > pcps_pkg::BOX_W) ?
                   COORD_BITS : pcps_pkg::BOX_W)-1:0] sq
);

  localparam int MW = (COORD_BITS > pcps_pkg::BOX_W) ? COORD_BITS : pcps_pkg::BOX_W;
  localparam int W  = MW + 2;

  logic signed [W-1:0] diff;
  logic signed [W-1:0] diff2;
  logic signed [W-1:0] box_s;
  logic signed [W-1:0] diff_c;
  logic [MW-1:0]       mag;
  logic [MW-1:0]       mag_r;
  logic [2*MW-1:0]     sq_r;

  // single minimum-image wrap; ties stay put, matching round-half-even
  always_comb begin
    diff  = $signed(W'(coord_a)) - $signed(W'(coord_b));
    diff2 = diff <<< 1;
    box_s = $signed(W'(box));
    if (diff2 > box_s) begin
      diff_c = diff - box_s;
    end else if (diff2 < -box_s) begin
      diff_c = diff + box_s;
    end else begin
      diff_c = diff;
    end
    if (diff_c[W-1]) begin
      mag = MW'(-diff_c);
    end else begin
      mag = MW'(diff_c);
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag;
    sq_r  <= mag_r * mag_r;
  end

  assign sq = sq_r;

endmodule

// ----- hdl/periodic_cutoff_pair_search.sv -----
// Channel   Direction  Handshake              Payload
// input     in         start, busy            in_op, in_pos_x/y/z, in_row_atom
// result    out        out_valid (strobe)     out_neighbour_index, out_found, out_last
// config    in         cfg_we                 cfg_index, cfg_wdata
//
// Load and clear never raise busy.
// A query passes each later atom through one shared axis unit (one multiplier),
// three axes in turn, then accumulate and compare.
// A row at or past the count answers with found low.
// Reset (rst_n low, synchronous) empties the store and restores the register values.
// The receiver cannot stall: each result strobes for exactly one cycle.
module periodic_cutoff_pair_search #(
  parameter int MAX_ATOMS  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic [pcps_pkg::COORD_IN_W-1:0]   in_pos_x,
  input  logic [pcps_pkg::COORD_IN_W-1:0]   in_pos_y,
  input  logic [pcps_pkg::COORD_IN_W-1:0]   in_pos_z,
  input  logic [pcps_pkg::ROW_W-1:0]        in_row_atom,
  output logic                              out_valid,
  output logic [pcps_pkg::IDX_OUT_W-1:0]    out_neighbour_index,
  output logic                              out_found,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [pcps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IW   = $clog2(MAX_ATOMS);
  localparam int CW   = $clog2(MAX_ATOMS + 1);
  localparam int MW   = (COORD_BITS > pcps_pkg::BOX_W) ? COORD_BITS : pcps_pkg::BOX_W;
  localparam int ACCW = 2 * MW + 2;
  localparam int CMPW = (CW > pcps_pkg::ROW_W) ? CW : pcps_pkg::ROW_W + 1;
  localparam int DW   = 3 * COORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CAP  = 4'b0010,
    ST_DIST = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    STEP_X     = 3'd0,
    STEP_Y     = 3'd1,
    STEP_Z     = 3'd2,
    STEP_ACC_Y = 3'd3,
    STEP_ACC_Z = 3'd4,
    STEP_CMP   = 3'd5
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] j_r, j_nxt, j_inc;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [ACCW-1:0] acc_r, acc_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [pcps_pkg::IDX_OUT_W-1:0] out_idx_r, out_idx_nxt;
  logic                         out_found_r, out_found_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [pcps_pkg::BOX_W-1:0]    box_x_r, box_y_r, box_z_r;
  logic [pcps_pkg::CUTOFF_W-1:0] cutoff_r;

  logic [DW-1:0] mem [MAX_ATOMS];
  logic [DW-1:0] rd_data_r;
  logic [DW-1:0] ri_r;
  logic [DW-1:0] wr_data;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr;

  logic                       accept;
  logic [COORD_BITS-1:0]      ax_a, ax_b;
  logic [pcps_pkg::BOX_W-1:0] ax_box;
  logic [2*MW-1:0]            ax_sq;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign j_inc   = j_r + CW'(1);
  assign wr_data = {COORD_BITS'(in_pos_x), COORD_BITS'(in_pos_y), COORD_BITS'(in_pos_z)};

  // axis select for the shared unit
  always_comb begin
    case (step_r)
      STEP_X: begin
        ax_a   = ri_r[3*COORD_BITS-1:2*COORD_BITS];
        ax_b   = rd_data_r[3*COORD_BITS-1:2*COORD_BITS];
        ax_box = box_x_r;
      end
      STEP_Y: begin
        ax_a   = ri_r[2*COORD_BITS-1:COORD_BITS];
        ax_b   = rd_data_r[2*COORD_BITS-1:COORD_BITS];
        ax_box = box_y_r;
      end
      default: begin
        ax_a   = ri_r[COORD_BITS-1:0];
        ax_b   = rd_data_r[COORD_BITS-1:0];
        ax_box = box_z_r;
      end
    endcase
  end

  pcps_axis_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_axis (
    .clk    (clk),
    .coord_a(ax_a),
    .coord_b(ax_b),
    .box    (ax_box),
    .sq     (ax_sq)
  );

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    count_nxt      = count_r;
    j_nxt          = j_r;
    pend_idx_nxt   = pend_idx_r;
    pend_valid_nxt = pend_valid_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = '0;
    out_found_nxt  = 1'b0;
    out_last_nxt   = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            pcps_pkg::OP_LOAD: begin
              if (count_r < CW'(MAX_ATOMS)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            pcps_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            pcps_pkg::OP_QUERY: begin
              if (CMPW'(in_row_atom) < CMPW'(count_r)) begin
                rd_en          = 1'b1;
                rd_addr        = in_row_atom[IW-1:0];
                j_nxt          = CW'(in_row_atom) + CW'(1);
                pend_valid_nxt = 1'b0;
                state_nxt      = ST_CAP;
              end else begin
                out_valid_nxt = 1'b1;
                out_last_nxt  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CAP: begin
        step_nxt = STEP_X;
        if (j_r < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = j_r[IW-1:0];
          state_nxt = ST_DIST;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIST: begin
        step_nxt = step_t'(step_r + 3'd1);
        case (step_r)
          STEP_Z: begin
            acc_nxt = ACCW'(ax_sq);
            // prefetch the next atom; this one is no longer needed
            if (j_inc < count_r) begin
              rd_en   = 1'b1;
              rd_addr = j_inc[IW-1:0];
            end
          end
          STEP_ACC_Y, STEP_ACC_Z: begin
            acc_nxt = acc_r + ACCW'(ax_sq);
          end
          STEP_CMP: begin
            // hold each hit until the next hit or the end so the final one can carry last
            if (acc_r < ACCW'(cutoff_r)) begin
              if (pend_valid_r) begin
                out_valid_nxt = 1'b1;
                out_found_nxt = 1'b1;
                out_idx_nxt   = pcps_pkg::IDX_OUT_W'(pend_idx_r);
              end
              pend_valid_nxt = 1'b1;
              pend_idx_nxt   = j_r[IW-1:0];
            end
            j_nxt    = j_inc;
            step_nxt = STEP_X;
            if (!(j_inc < count_r)) begin
              state_nxt = ST_FIN;
            end
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_found_nxt = pend_valid_r;
        out_idx_nxt   = pend_valid_r ? pcps_pkg::IDX_OUT_W'(pend_idx_r) : '0;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STEP_X;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      box_x_r      <= 16'hFFFF;
      box_y_r      <= 16'hFFFF;
      box_z_r      <= 16'hFFFF;
      cutoff_r     <= 32'd1048576;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pcps_pkg::REG_BOX_X:  box_x_r  <= cfg_wdata[pcps_pkg::BOX_W-1:0];
          pcps_pkg::REG_BOX_Y:  box_y_r  <= cfg_wdata[pcps_pkg::BOX_W-1:0];
          pcps_pkg::REG_BOX_Z:  box_z_r  <= cfg_wdata[pcps_pkg::BOX_W-1:0];
          pcps_pkg::REG_CUTOFF: cutoff_r <= cfg_wdata[pcps_pkg::CUTOFF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r         <= j_nxt;
    pend_idx_r  <= pend_idx_nxt;
    acc_r       <= acc_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
    if (state_r == ST_CAP) begin
      ri_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_neighbour_index = out_idx_r;
  assign out_found           = out_found_r;
  assign out_last            = out_last_r;

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ATOMS = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [5:0]  row;
  } atom_cmd_t;

  typedef struct packed {
    logic [5:0] nbr_idx;
    logic       found;
    logic       last;
  } row_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = pcps_pkg::OP_LOAD;
  logic [15:0] in_pos_x = '0;
  logic [15:0] in_pos_y = '0;
  logic [15:0] in_pos_z = '0;
  logic [5:0]  in_row_atom = '0;
  logic        out_valid;
  logic [5:0]  out_neighbour_index;
  logic        out_found;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = pcps_pkg::REG_BOX_X;
  logic [31:0] cfg_wdata = '0;

  atom_cmd_t   cmd_queue[$];
  atom_cmd_t   next_cmd;
  row_result_t expected_neighbours[$];
  int          idle_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // mirror of the block's state and registers
  logic [15:0] atom_x [MAX_ATOMS];
  logic [15:0] atom_y [MAX_ATOMS];
  logic [15:0] atom_z [MAX_ATOMS];
  int          stored_atoms = 0;
  logic [15:0] box_len [3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
  logic [31:0] cutoff_lim = 32'd1048576;

  periodic_cutoff_pair_search i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pos_z            (in_pos_z),
    .in_row_atom         (in_row_atom),
    .out_valid           (out_valid),
    .out_neighbour_index (out_neighbour_index),
    .out_found           (out_found),
    .out_last            (out_last),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // squared minimum-image separation along one axis
  function automatic longint unsigned axis_sq(logic [15:0] a, logic [15:0] b,
                                              logic [15:0] len);
    longint pa, pb, l, d;
    pa = a;
    pb = b;
    l = len;
    d = pa - pb;
    if (2 * d > l) d = d - l;
    else if (2 * d < -l) d = d + l;
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic void search_row(logic [5:0] row);
    row_result_t     hits[$];
    row_result_t     r;
    longint unsigned dist_sq;
    for (int j = int'(row) + 1; j < stored_atoms; j++) begin
      dist_sq = axis_sq(atom_x[row], atom_x[j], box_len[0])
              + axis_sq(atom_y[row], atom_y[j], box_len[1])
              + axis_sq(atom_z[row], atom_z[j], box_len[2]);
      if (dist_sq < cutoff_lim) begin
        r.nbr_idx = 6'(j);
        r.found = 1'b1;
        r.last = 1'b0;
        hits.push_back(r);
      end
    end
    if (hits.size() == 0) begin
      r.nbr_idx = '0;
      r.found = 1'b0;
      r.last = 1'b1;
      hits.push_back(r);
    end
    hits[hits.size() - 1].last = 1'b1;
    foreach (hits[k]) expected_neighbours.push_back(hits[k]);
  endfunction

  function automatic void apply_cmd(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] z, logic [5:0] row);
    case (op)
      pcps_pkg::OP_LOAD: begin
        if (stored_atoms < MAX_ATOMS) begin
          atom_x[stored_atoms] = x;
          atom_y[stored_atoms] = y;
          atom_z[stored_atoms] = z;
          stored_atoms++;
        end
      end
      pcps_pkg::OP_QUERY: search_row(row);
      pcps_pkg::OP_CLEAR: stored_atoms = 0;
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // driver: hold the item while busy, otherwise present the next one or idle
  always @(posedge clk) begin
    if (rst_n && !(start && busy)) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_cmd = cmd_queue.pop_front();
        start <= 1'b1;
        in_op <= next_cmd.op;
        in_pos_x <= next_cmd.x;
        in_pos_y <= next_cmd.y;
        in_pos_z <= next_cmd.z;
        in_row_atom <= next_cmd.row;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // predict on acceptance, then check any result of this cycle
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (start && !busy) begin
        quiet_cycles = 0;
        apply_cmd(in_op, in_pos_x, in_pos_y, in_pos_z, in_row_atom);
      end
      if (cfg_we) quiet_cycles = 0;
      if (out_valid) begin
        quiet_cycles = 0;
        if (expected_neighbours.size() == 0) begin
          $display("%0t: result with none expected, index %0d found %0d last %0d",
                   $time, out_neighbour_index, out_found, out_last);
          mismatches++;
        end else begin
          compare_field("neighbour_index", expected_neighbours[0].nbr_idx,
                        out_neighbour_index);
          compare_field("found", expected_neighbours[0].found, out_found);
          compare_field("last", expected_neighbours[0].last, out_last);
          void'(expected_neighbours.pop_front());
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no activity for %0d cycles", $time, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic add_load(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    atom_cmd_t c;
    c.op = pcps_pkg::OP_LOAD;
    c.x = x;
    c.y = y;
    c.z = z;
    c.row = 6'($urandom);
    cmd_queue.push_back(c);
  endtask

  task automatic add_op(logic [1:0] op, logic [5:0] row);
    atom_cmd_t c;
    c.op = op;
    c.x = 16'($urandom);
    c.y = 16'($urandom);
    c.z = 16'($urandom);
    c.row = row;
    cmd_queue.push_back(c);
  endtask

  // wait until every item is taken, every result is in and the block is idle
  task automatic drain();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || start || busy || expected_neighbours.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(pcps_pkg::cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pcps_pkg::REG_BOX_X:  box_len[0] = val[15:0];
      pcps_pkg::REG_BOX_Y:  box_len[1] = val[15:0];
      pcps_pkg::REG_BOX_Z:  box_len[2] = val[15:0];
      pcps_pkg::REG_CUTOFF: cutoff_lim = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper data bits of the box writes carry junk that must be dropped
  task automatic set_config(logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                            logic [31:0] cut);
    drain();
    write_reg(pcps_pkg::REG_BOX_X, ($urandom << 16) | bx);
    write_reg(pcps_pkg::REG_BOX_Y, ($urandom << 16) | by);
    write_reg(pcps_pkg::REG_BOX_Z, ($urandom << 16) | bz);
    write_reg(pcps_pkg::REG_CUTOFF, cut);
    @(negedge clk);
  endtask

  task automatic random_config(output int unsigned spread);
    logic [15:0] b [3];
    spread = ($urandom_range(3) == 0) ? $urandom_range(1, 4096) : $urandom_range(8, 600);
    foreach (b[a]) begin
      case ($urandom_range(3))
        0: b[a] = 16'hFFFF;
        1: b[a] = 16'($urandom_range(1, 65535));
        2: b[a] = 16'($urandom_range(1, 4 * spread));
        default: b[a] = 16'd1;
      endcase
    end
    set_config(b[0], b[1], b[2], $urandom_range(0, 3 * spread * spread));
  endtask

  // clear, load a cluster of atoms around a random center, query some rows
  task automatic atom_set(int unsigned spread);
    int unsigned n, cx, cy, cz, nq, row;
    n = ($urandom_range(11) == 0) ? $urandom_range(40, 64) : $urandom_range(2, 10);
    cx = $urandom;
    cy = $urandom;
    cz = $urandom;
    add_op(pcps_pkg::OP_CLEAR, 6'($urandom));
    for (int k = 0; k < n; k++)
      add_load(16'(cx + $urandom_range(spread)), 16'(cy + $urandom_range(spread)),
               16'(cz + $urandom_range(spread)));
    nq = $urandom_range(2, 5);
    for (int q = 0; q < nq; q++) begin
      row = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(n);
      add_op(pcps_pkg::OP_QUERY, 6'(row));
    end
    if ($urandom_range(3) == 0) add_op(OP_UNUSED, 6'($urandom));
    if ($urandom_range(4) == 0) drain();
  endtask

  initial begin
    int unsigned spread;
    int pct [4] = '{0, 73, 31, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: wrap across the box edge, cutoff boundary, empty store
    add_op(pcps_pkg::OP_QUERY, 6'd0);
    add_load(16'h0000, 16'h0000, 16'h0000);
    add_load(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_load(16'd1023, 16'h0000, 16'h0000);
    add_load(16'd1024, 16'h0000, 16'h0000);
    add_load(16'h8000, 16'h7FFF, 16'h0000);
    for (int r = 0; r < 5; r++) add_op(pcps_pkg::OP_QUERY, 6'(r));
    add_op(pcps_pkg::OP_QUERY, 6'd63);
    add_op(OP_UNUSED, 6'd0);
    add_op(pcps_pkg::OP_CLEAR, 6'd0);
    add_op(pcps_pkg::OP_QUERY, 6'd0);

    // half-box ties on x, unit box on y, zero box on z
    set_config(16'd2048, 16'd1, 16'd0, 32'd1048577);
    add_op(pcps_pkg::OP_CLEAR, 6'd0);
    add_load(16'd0, 16'd0, 16'd0);
    add_load(16'd1024, 16'd5, 16'd9);
    add_load(16'd1025, 16'd0, 16'd0);
    add_op(pcps_pkg::OP_QUERY, 6'd0);
    add_op(pcps_pkg::OP_QUERY, 6'd1);

    // largest cutoff: every pair is kept; overfill the store
    idle_pct = 31;
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(pcps_pkg::OP_CLEAR, 6'd0);
    for (int k = 0; k < MAX_ATOMS + 2; k++)
      add_load(16'($urandom), 16'($urandom), 16'($urandom));
    add_op(pcps_pkg::OP_QUERY, 6'd0);
    add_op(pcps_pkg::OP_QUERY, 6'd62);
    add_op(pcps_pkg::OP_QUERY, 6'd63);
    add_op(pcps_pkg::OP_QUERY, 6'($urandom_range(63)));

    // zero cutoff: every row comes back empty
    idle_pct = 73;
    set_config(16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)), 32'd0);
    atom_set(300);
    atom_set(5);

    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p];
      for (int c = 0; c < 2; c++) begin
        random_config(spread);
        for (int s = 0; s < 2; s++) atom_set(spread);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
